>>> rtl/core/dnle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS name label encoder package
// Shared widths, character codes and the words passed between front and back.
// ----------------------------------------------------------------------------
package dnle_pkg;

  localparam int LEN_W      = 6;    // label length, up to 62
  localparam int NAME_CNT_W = 8;    // name character count, up to NAME_MAX
  localparam int NAME_MAX   = 255;

  localparam logic [7:0] CH_END = 8'd0;
  localparam logic [7:0] CH_DOT = 8'd46;

  // One command per name event: a label to replay and/or a closing word.
  typedef struct packed {
    logic             has_label;
    logic [LEN_W-1:0] len;
    logic             bank;
    logic             term;
    logic             err;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } ram_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } out_t;

endpackage
`default_nettype wire

>>> rtl/core/dns_name_label_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS name label encoder
// Turns a dotted host name, one character a word, into DNS wire form.
// ----------------------------------------------------------------------------
//   channel  | handshake   | fields
//   ---------+-------------+---------------------------
//   input    | push / full | ch
//   result   | empty / pop | out_byte, last, error
//
// The front takes one character per cycle and writes it into one of two
// label banks. For each label the back fetches its command, then emits its
// length word and then its characters. The front stalls while the bank
// it would fill is still being replayed or the command queue is full.
// Reset (rst, synchronous) empties both queues and clears all counts.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_unit #(
  parameter int LABEL_MAX = 62
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] ch,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            last,
  output logic            error
);

  dnle_pkg::cmd_t     cmd;
  dnle_pkg::cmd_t     q_head;
  dnle_pkg::ram_wr_t  wr;
  dnle_pkg::release_t rel;
  logic               cmd_push;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;

  dnle_front #(
    .LABEL_MAX (LABEL_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .ch       (ch),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd      (cmd),
    .wr       (wr),
    .rel      (rel)
  );

  dnle_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_cmd  (cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_cmd  (q_head),
    .q_empty (q_empty)
  );

  dnle_back #(
    .LABEL_MAX (LABEL_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rel      (rel),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last),
    .error    (error)
  );

endmodule
`default_nettype wire

>>> rtl/core/dnle_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue of label commands between the front and the back.
// ----------------------------------------------------------------------------
module dnle_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire dnle_pkg::cmd_t wr_cmd,
  output logic               q_full,
  input  wire logic          rd_en,
  output dnle_pkg::cmd_t     rd_cmd,
  output logic               q_empty
);

  dnle_pkg::cmd_t entries [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dnle_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Classifies name characters, fills the label banks and issues commands.
// ----------------------------------------------------------------------------
module dnle_front #(
  parameter int LABEL_MAX = 62
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        ch,
  input  wire logic              q_full,
  output logic                   cmd_push,
  output dnle_pkg::cmd_t         cmd,
  output dnle_pkg::ram_wr_t      wr,
  input  wire dnle_pkg::release_t rel
);

  logic [dnle_pkg::LEN_W-1:0]      label_count, label_count_next;
  logic [dnle_pkg::NAME_CNT_W-1:0] name_count, name_count_next;
  logic                            overflow_seen, overflow_seen_next;
  logic                            bank, bank_next;
  logic [1:0]                      busy, busy_next;
  logic                            accept;
  logic                            is_end;
  logic                            is_dot;

  // Hold off while the bank being filled is still being replayed or the command queue is full.
  assign full   = q_full | busy[bank];
  assign accept = push & ~full;
  assign is_end = (ch == dnle_pkg::CH_END);
  assign is_dot = (ch == dnle_pkg::CH_DOT);

  always_comb begin
    label_count_next   = label_count;
    name_count_next    = name_count;
    overflow_seen_next = overflow_seen;
    bank_next          = bank;
    busy_next          = busy;
    cmd_push           = 1'b0;
    cmd                = '0;
    cmd.bank           = bank;
    cmd.len            = label_count;
    wr                 = '0;
    wr.bank            = bank;
    wr.idx             = label_count;
    wr.data            = ch;

    if (rel.en) begin
      busy_next[rel.bank] = 1'b0;
    end

    if (accept) begin
      if (overflow_seen) begin
        if (is_end) begin
          cmd_push           = 1'b1;
          cmd.term           = 1'b1;
          cmd.err            = 1'b1;
          label_count_next   = '0;
          name_count_next    = '0;
          overflow_seen_next = 1'b0;
        end
      end else if (is_end) begin
        cmd_push           = 1'b1;
        cmd.has_label      = (label_count != '0);
        cmd.term           = 1'b1;
        label_count_next   = '0;
        name_count_next    = '0;
        overflow_seen_next = 1'b0;
        if (label_count != '0) begin
          busy_next[bank] = 1'b1;
          bank_next       = ~bank;
        end
      end else if (name_count >= dnle_pkg::NAME_CNT_W'(dnle_pkg::NAME_MAX)) begin
        overflow_seen_next = 1'b1;
      end else if (is_dot) begin
        cmd_push         = 1'b1;
        cmd.has_label    = 1'b1;
        name_count_next  = name_count + 1'b1;
        label_count_next = '0;
        busy_next[bank]  = 1'b1;
        bank_next        = ~bank;
      end else if (label_count >= dnle_pkg::LEN_W'(LABEL_MAX)) begin
        overflow_seen_next = 1'b1;
      end else begin
        wr.en            = 1'b1;
        label_count_next = label_count + 1'b1;
        name_count_next  = name_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      label_count   <= '0;
      name_count    <= '0;
      overflow_seen <= 1'b0;
      bank          <= 1'b0;
      busy          <= 2'b00;
    end else begin
      label_count   <= label_count_next;
      name_count    <= name_count_next;
      overflow_seen <= overflow_seen_next;
      bank          <= bank_next;
      busy          <= busy_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dnle_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Replays each label from its bank after the length word and closes names.
// ----------------------------------------------------------------------------
module dnle_back #(
  parameter int LABEL_MAX = 62
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dnle_pkg::ram_wr_t wr,
  output dnle_pkg::release_t     rel,
  input  wire dnle_pkg::cmd_t    q_head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             out_byte,
  output logic                   last,
  output logic                   error
);

  localparam int IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_DATA,
    S_TERM
  } state_t;

  state_t                     state;
  dnle_pkg::cmd_t             cur;
  logic [dnle_pkg::LEN_W-1:0] idx;

  logic [7:0] label_store [0:1][0:LABEL_MAX-1];
  logic [7:0] rdata;

  // word in flight between sequencer and output queue
  logic       p_valid;
  logic       p_mem;
  logic [7:0] p_byte;
  logic       p_last;
  logic       p_err;

  dnle_pkg::out_t oq [0:3];
  logic [1:0]     oq_wr_ptr;
  logic [1:0]     oq_rd_ptr;
  logic [2:0]     oq_count;
  logic           oq_pop;
  dnle_pkg::out_t oq_in;

  logic       can_produce;
  logic       produce;
  logic       prod_mem;
  logic [7:0] prod_byte;
  logic       prod_last;
  logic       prod_err;
  logic       label_done;

  assign can_produce = ((oq_count + {2'b00, p_valid}) < 3'd4);
  assign q_pop       = (state == S_IDLE) & ~q_empty;
  assign label_done  = (idx == (cur.len - 1'b1));

  always_comb begin
    produce   = 1'b0;
    prod_mem  = 1'b0;
    prod_byte = 8'd0;
    prod_last = 1'b0;
    prod_err  = 1'b0;
    rel       = '0;
    rel.bank  = cur.bank;
    case (state)
      S_LEN: begin
        produce   = can_produce;
        prod_byte = {{(8 - dnle_pkg::LEN_W){1'b0}}, cur.len};
        rel.en    = can_produce & (cur.len == '0);
      end
      S_DATA: begin
        produce  = can_produce;
        prod_mem = 1'b1;
        rel.en   = can_produce & label_done;
      end
      S_TERM: begin
        produce   = can_produce;
        prod_last = 1'b1;
        prod_err  = cur.err;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      label_store[wr.bank][wr.idx[IDX_W-1:0]] <= wr.data;
    end
    if (produce & prod_mem) begin
      rdata <= label_store[cur.bank][idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      p_valid <= 1'b0;
    end else begin
      p_valid <= produce;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_head;
            state <= q_head.has_label ? S_LEN : S_TERM;
          end
        end
        S_LEN: begin
          if (can_produce) begin
            idx <= '0;
            if (cur.len == '0) begin
              state <= cur.term ? S_TERM : S_IDLE;
            end else begin
              state <= S_DATA;
            end
          end
        end
        S_DATA: begin
          if (can_produce) begin
            idx <= idx + 1'b1;
            if (label_done) begin
              state <= cur.term ? S_TERM : S_IDLE;
            end
          end
        end
        S_TERM: begin
          if (can_produce) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    p_mem  <= prod_mem;
    p_byte <= prod_byte;
    p_last <= prod_last;
    p_err  <= prod_err;
  end

  // output queue
  assign oq_in.data = p_mem ? rdata : p_byte;
  assign oq_in.last = p_last;
  assign oq_in.err  = p_err;
  assign empty      = (oq_count == 3'd0);
  assign oq_pop     = pop & ~empty;
  assign out_byte   = oq[oq_rd_ptr].data;
  assign last       = oq[oq_rd_ptr].last;
  assign error      = oq[oq_rd_ptr].err;

  always_ff @(posedge clk) begin
    if (p_valid) begin
      oq[oq_wr_ptr] <= oq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr_ptr <= 2'd0;
      oq_rd_ptr <= 2'd0;
      oq_count  <= 3'd0;
    end else begin
      if (p_valid) begin
        oq_wr_ptr <= oq_wr_ptr + 2'd1;
      end
      if (oq_pop) begin
        oq_rd_ptr <= oq_rd_ptr + 2'd1;
      end
      case ({p_valid, oq_pop})
        2'b10:   oq_count <= oq_count + 3'd1;
        2'b01:   oq_count <= oq_count - 3'd1;
        default: oq_count <= oq_count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> verif/dns_name_label_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS name label encoder testbench
// Feeds host names one character per word and checks every wire-form word
// against a predictor kept in step with the accepted characters: short names,
// empty labels, label and name overflow, then random names under idling.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_unit_tb;

  localparam int LABEL_LIMIT = 62;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] ch;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  dns_name_label_encoder_unit #(
    .LABEL_MAX(LABEL_LIMIT)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .ch      (ch),
    .empty   (empty),
    .pop     (pop),
    .out_byte(out_byte),
    .last    (last),
    .error   (error)
  );

  // Predictor state
  logic [7:0]     label_chars[LABEL_LIMIT];
  logic [5:0]     label_len;
  logic [8:0]     name_len;
  logic           discarding;
  dnle_pkg::out_t wire_bytes_q[$];

  int  mismatch_cnt;
  int  pop_hold;
  bit  quiet;

  always #5 clk = ~clk;

  function automatic void emit_label();
    wire_bytes_q.push_back(dnle_pkg::out_t'{data: 8'(label_len), last: 1'b0, err: 1'b0});
    for (int i = 0; i < label_len; i++)
      wire_bytes_q.push_back(dnle_pkg::out_t'{data: label_chars[i], last: 1'b0, err: 1'b0});
    label_len = '0;
  endfunction

  function automatic void clear_name();
    label_len  = '0;
    name_len   = '0;
    discarding = 1'b0;
  endfunction

  function automatic void encode_char(logic [7:0] c);
    if (discarding) begin
      if (c == dnle_pkg::CH_END) begin
        wire_bytes_q.push_back(dnle_pkg::out_t'{data: 8'd0, last: 1'b1, err: 1'b1});
        clear_name();
      end
    end else if (c == dnle_pkg::CH_END) begin
      // a trailing empty label is not emitted
      if (label_len != 0)
        emit_label();
      wire_bytes_q.push_back(dnle_pkg::out_t'{data: 8'd0, last: 1'b1, err: 1'b0});
      clear_name();
    end else if (name_len >= dnle_pkg::NAME_MAX) begin
      discarding = 1'b1;
    end else if (c == dnle_pkg::CH_DOT) begin
      name_len++;
      emit_label();
    end else if (label_len >= LABEL_LIMIT) begin
      discarding = 1'b1;
    end else begin
      label_chars[label_len] = c;
      label_len++;
      name_len++;
    end
  endfunction

  function automatic logic [7:0] rand_label_char();
    logic [7:0] c;
    do
      c = 8'($urandom_range(1, 255));
    while (c == dnle_pkg::CH_DOT);
    return c;
  endfunction

  // Hold push high until the word is taken, then leave it high; gaps are random.
  task automatic send_char(logic [7:0] c);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    push <= 1'b1;
    ch   <= c;
    do
      @(posedge clk);
    while (full);
    encode_char(c);
  endtask

  task automatic send_label(int n);
    repeat (n) send_char(rand_label_char());
  endtask

  // Result side: check each popped word, then pick pop for the next cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (wire_bytes_q.size() == 0) begin
          $display("%0t: unexpected word expected none actual byte %0h last %0b error %0b",
                   $time, out_byte, last, error);
          mismatch_cnt++;
        end else begin
          if (out_byte !== wire_bytes_q[0].data) begin
            $display("%0t: out_byte expected %0h actual %0h",
                     $time, wire_bytes_q[0].data, out_byte);
            mismatch_cnt++;
          end
          if (last !== wire_bytes_q[0].last) begin
            $display("%0t: last expected %0b actual %0b", $time, wire_bytes_q[0].last, last);
            mismatch_cnt++;
          end
          if (error !== wire_bytes_q[0].err) begin
            $display("%0t: error expected %0b actual %0b", $time, wire_bytes_q[0].err, error);
            mismatch_cnt++;
          end
          void'(wire_bytes_q.pop_front());
        end
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop_hold = $urandom_range(1, 7) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic test_short_names();
    send_char(dnle_pkg::CH_END);             // root only
    send_char(8'h01);
    send_char(dnle_pkg::CH_END);
    send_char(8'hFF);
    send_char(dnle_pkg::CH_DOT);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(dnle_pkg::CH_END);
    send_char(8'h55);
    send_char(8'hAA);
    send_char(dnle_pkg::CH_DOT);             // trailing dot adds no label
    send_char(dnle_pkg::CH_END);
  endtask

  task automatic test_empty_labels();
    send_char(dnle_pkg::CH_DOT);             // leading dot
    send_char(8'h61);
    send_char(dnle_pkg::CH_DOT);
    send_char(dnle_pkg::CH_DOT);             // two dots in a row
    send_char(8'h62);
    send_char(dnle_pkg::CH_END);
    send_char(dnle_pkg::CH_DOT);             // lone dot
    send_char(dnle_pkg::CH_END);
  endtask

  task automatic test_label_too_long();
    send_label(LABEL_LIMIT);                 // longest legal label
    send_char(dnle_pkg::CH_END);
    send_label(LABEL_LIMIT + 1);
    send_label(3);
    send_char(dnle_pkg::CH_DOT);
    send_char(8'h41);
    send_char(dnle_pkg::CH_END);
    send_label(2);                           // next name is clean again
    send_char(dnle_pkg::CH_END);
  endtask

  // 4 x (62 + dot) + 3 puts the name count right at NAME_MAX.
  task automatic fill_name();
    repeat (4) begin
      send_label(LABEL_LIMIT);
      send_char(dnle_pkg::CH_DOT);
    end
    send_label(3);
  endtask

  task automatic test_name_too_long();
    fill_name();
    send_char(dnle_pkg::CH_END);
    fill_name();
    send_char(8'h30);
    send_label(5);
    send_char(dnle_pkg::CH_END);
    fill_name();
    send_char(dnle_pkg::CH_DOT);             // a dot past the limit overflows too
    send_char(dnle_pkg::CH_END);
  endtask

  task automatic test_random_names();
    int sent;
    int n_labels;
    int len;
    sent = 0;
    while (sent < 120) begin
      if (sent > 80)
        quiet = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        // noise: any byte value
        len = $urandom_range(1, 6);
        repeat (len) send_char(8'($urandom_range(0, 255)));
        sent += len;
      end else begin
        n_labels = $urandom_range(1, 4);
        for (int l = 0; l < n_labels; l++) begin
          if ($urandom_range(0, 15) == 0)
            len = $urandom_range(LABEL_LIMIT - 2, LABEL_LIMIT + 1);
          else
            len = $urandom_range(0, 8);
          send_label(len);
          sent += len;
          if (l < n_labels - 1 || $urandom_range(0, 3) == 0) begin
            send_char(dnle_pkg::CH_DOT);
            sent++;
          end
        end
        send_char(dnle_pkg::CH_END);
        sent++;
      end
    end
    send_char(dnle_pkg::CH_END);             // close anything noise left open
  endtask

  initial begin
    clk          = 1'b0;
    mismatch_cnt = 0;
    pop_hold     = 0;
    quiet        = 1'b0;
    clear_name();
    rst  <= 1'b1;
    push <= 1'b0;
    pop  <= 1'b0;
    ch   <= 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_short_names();
    test_empty_labels();
    test_label_too_long();
    test_name_too_long();
    test_random_names();
    push <= 1'b0;

    wait (wire_bytes_q.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0 && wire_bytes_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
rtl/core/dnle_pkg.sv
rtl/core/dnle_cmd_queue.sv
rtl/core/dnle_front.sv
rtl/core/dnle_back.sv
rtl/core/dns_name_label_encoder_unit.sv
verif/dns_name_label_encoder_unit_tb.sv
